// ===== hw/rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// Types, codes and the key function for the sorted priority queue.
// No dependencies; used by every module of the block.
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_W     = 9;
    localparam int ID_W      = 8;
    localparam int CNT_OUT_W = 5;

    localparam logic [1:0] OP_ENQ    = 2'd0;
    localparam logic [1:0] OP_DEQ    = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] TYPE_AGILE = 2'd0;
    localparam logic [1:0] TYPE_TANK  = 2'd1;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // floor(x*4/5) == (x*820) >> 10 for every 8-bit x
    localparam logic [9:0] TANK_RECIP = 10'd820;

    typedef struct packed {
        logic [1:0]      op;
        logic [ID_W-1:0] character_id;
        logic [7:0]      agility;
        logic [1:0]      char_type;
        logic            alive;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]      head_id;
        logic [KEY_W-1:0]     head_key;
        logic [CNT_OUT_W-1:0] count;
        logic                 is_empty;
        logic [1:0]           error;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_ent;

    typedef struct packed {
        logic [1:0] op;
        t_ent       ent;
    } t_key_req;

    typedef struct packed {
        logic             enq;
        logic             deq;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

    function automatic logic [KEY_W-1:0] key_of(input logic [7:0] agility,
                                                input logic [1:0] char_type,
                                                input logic       alive);
        logic [17:0]      prod;
        logic [KEY_W-1:0] k;
        prod = {10'd0, agility} * {8'd0, TANK_RECIP};
        k    = '0;
        if (alive) begin
            case (char_type)
                TYPE_AGILE: k = {1'b0, agility} + {2'b00, agility[7:1]};
                TYPE_TANK:  k = {1'b0, prod[17:10]};
                default:    k = '0;
            endcase
        end
        return k;
    endfunction

endpackage

// ===== hw/rtl/sorted_priority_queue_core.sv =====
`timescale 1ns / 1ps
// Sorted priority queue: key stage, a row of DEPTH cells, result register.
// A request is registered in the key stage, then its result in the result register; a stall holds both.
// Throughput: one request per cycle while the result is not stalled; the whole cell row updates together.
// Reset clears the entry count and the stage valids; stored entries are not cleared.
// Depends on spq_pkg, spq_key and spq_cell.
module sorted_priority_queue_core #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  spq_pkg::t_req i_req,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output spq_pkg::t_rsp o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic              w_a_valid;
    spq_pkg::t_key_req w_kreq;
    logic              w_take;
    logic              w_full;
    logic              w_enq_ok;
    logic              w_deq_ok;
    spq_pkg::t_cell_ctl w_ctl;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_o_valid;
    logic              n_o_valid;
    spq_pkg::t_rsp     r_rsp;
    spq_pkg::t_rsp     n_rsp;
    logic [31:0]       w_count_ext;

    spq_pkg::t_ent     w_data [DEPTH];
    spq_pkg::t_ent     w_next [DEPTH];
    logic              w_ge   [DEPTH];

    spq_key u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_stall (o_stall),
        .i_take  (w_take),
        .o_valid (w_a_valid),
        .o_kreq  (w_kreq)
    );

    assign w_take   = w_a_valid && (!r_o_valid || !i_stall);
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_enq_ok = w_take && (w_kreq.op == spq_pkg::OP_ENQ) && !w_full;
    assign w_deq_ok = w_take && (w_kreq.op == spq_pkg::OP_DEQ) && (r_count != '0);

    assign w_ctl.enq = w_enq_ok;
    assign w_ctl.deq = w_deq_ok;
    assign w_ctl.key = w_kreq.ent.key;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        spq_pkg::t_ent w_left;
        spq_pkg::t_ent w_right;
        logic          w_left_ge;

        if (g == 0) begin : g_first
            assign w_left    = w_kreq.ent;
            assign w_left_ge = 1'b1;
        end else begin : g_mid
            assign w_left    = w_data[g-1];
            assign w_left_ge = w_ge[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_new     (w_kreq.ent),
            .i_occ     (r_count > CW'(g)),
            .i_left    (w_left),
            .i_left_ge (w_left_ge),
            .i_right   (w_right),
            .o_data    (w_data[g]),
            .o_ge      (w_ge[g]),
            .o_next    (w_next[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_enq_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_deq_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_count_ext = 32'(n_count);

    always_comb begin
        n_rsp.count = w_count_ext[spq_pkg::CNT_OUT_W-1:0];
        if (n_count == '0) begin
            n_rsp.head_id  = '0;
            n_rsp.head_key = '0;
            n_rsp.is_empty = 1'b1;
        end else begin
            n_rsp.head_id  = w_next[0].id;
            n_rsp.head_key = w_next[0].key;
            n_rsp.is_empty = 1'b0;
        end
        n_rsp.error = spq_pkg::ERR_OK;
        if ((w_kreq.op == spq_pkg::OP_ENQ) && w_full) begin
            n_rsp.error = spq_pkg::ERR_FULL;
        end else if ((w_kreq.op == spq_pkg::OP_DEQ) && (r_count == '0)) begin
            n_rsp.error = spq_pkg::ERR_EMPTY;
        end
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (w_take) begin
            n_o_valid = 1'b1;
        end else if (!i_stall) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_o_valid;
    assign o_rsp   = r_rsp;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_full_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (w_kreq.op == spq_pkg::OP_ENQ) && w_full) |=> $stable(r_count))
        else $error("enqueue into full queue changed count");

    a_deq_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_deq_ok |=> (r_count == $past(r_count) - CW'(1)))
        else $error("dequeue did not drop one entry");

    a_head_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_data[0].key >= w_data[1].key))
        else $error("head entries out of order");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall && !w_take) |=> $stable(r_rsp))
        else $error("stalled result changed");

endmodule

// ===== hw/rtl/spq_key.sv =====
`timescale 1ns / 1ps
// Input stage: registers one request and its computed priority key.
// Depends on spq_pkg.
module spq_key (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  spq_pkg::t_req     i_req,
    output logic              o_stall,
    input  logic              i_take,
    output logic              o_valid,
    output spq_pkg::t_key_req o_kreq
);

    logic              r_valid;
    logic              n_valid;
    spq_pkg::t_key_req r_kreq;
    logic              w_accept;

    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kreq.op     <= i_req.op;
            r_kreq.ent.id <= i_req.character_id;
            r_kreq.ent.key <= spq_pkg::key_of(i_req.agility, i_req.char_type, i_req.alive);
        end
    end

    assign o_valid = r_valid;
    assign o_kreq  = r_kreq;

endmodule

// ===== hw/rtl/spq_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted row: holds an entry, keeps, loads the new entry,
// or takes a neighbour's entry. Depends on spq_pkg.
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  spq_pkg::t_ent      i_new,
    input  logic               i_occ,
    input  spq_pkg::t_ent      i_left,
    input  logic               i_left_ge,
    input  spq_pkg::t_ent      i_right,
    output spq_pkg::t_ent      o_data,
    output logic               o_ge,
    output spq_pkg::t_ent      o_next
);

    spq_pkg::t_ent r_ent;
    spq_pkg::t_ent n_ent;

    assign o_ge = i_occ && (r_ent.key >= i_ctl.key);

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.enq && !o_ge) begin
            n_ent = i_left_ge ? i_new : i_left;
        end else if (i_ctl.deq) begin
            n_ent = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_data = r_ent;
    assign o_next = n_ent;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sorted_priority_queue_core: a queue-fed request driver,
// a result monitor and a behavioural model of the sorted queue that predicts every result.
// Depends on spq_pkg and the sorted_priority_queue_core RTL.
module tb_top;

    localparam int         QDEPTH      = spq_pkg::DEPTH_DEF;
    localparam int         STALL_LIMIT = 5000;
    localparam int         PHASE_REQS  = 375;
    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam logic [1:0] TYPE_OTHER  = 2'd2;
    localparam logic [1:0] TYPE_SPARE  = 2'd3;
    localparam int         BURST_FILL  = 0;
    localparam int         BURST_DRAIN = 1;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    spq_pkg::t_req i_req = '0;
    logic o_stall;
    logic o_valid;
    logic i_stall = 1'b0;
    spq_pkg::t_rsp o_rsp;

    spq_pkg::t_req request_queue [$];
    spq_pkg::t_rsp predicted_rsp [$];

    logic [spq_pkg::KEY_W-1:0] model_keys [QDEPTH];
    logic [spq_pkg::ID_W-1:0]  model_ids  [QDEPTH];
    int                        model_held = 0;

    int sender_idle_pct = 0;
    int recv_idle_pct   = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;

    sorted_priority_queue_core #(
        .DEPTH(QDEPTH)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_req  (i_req),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rsp  (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [spq_pkg::KEY_W-1:0] priority_of(logic [7:0] agility,
                                                              logic [1:0] kind,
                                                              logic alive);
        int v;
        v = 0;
        if (alive) begin
            case (kind)
                spq_pkg::TYPE_AGILE: v = (int'(agility) * 3) / 2;
                spq_pkg::TYPE_TANK:  v = (int'(agility) * 4) / 5;
                default:             v = 0;
            endcase
        end
        return v[spq_pkg::KEY_W-1:0];
    endfunction

    function automatic spq_pkg::t_rsp advance_queue_model(spq_pkg::t_req r);
        spq_pkg::t_rsp             res;
        logic [spq_pkg::KEY_W-1:0] k;
        int                        pos;
        res = '0;
        res.error = spq_pkg::ERR_OK;
        case (r.op)
            spq_pkg::OP_ENQ: begin
                if (model_held >= QDEPTH) begin
                    res.error = spq_pkg::ERR_FULL;
                end else begin
                    k = priority_of(r.agility, r.char_type, r.alive);
                    pos = 0;
                    while (pos < model_held && model_keys[pos] >= k)
                        pos++;
                    for (int i = model_held; i > pos; i--) begin
                        model_keys[i] = model_keys[i-1];
                        model_ids[i]  = model_ids[i-1];
                    end
                    model_keys[pos] = k;
                    model_ids[pos]  = r.character_id;
                    model_held++;
                end
            end
            spq_pkg::OP_DEQ: begin
                if (model_held == 0) begin
                    res.error = spq_pkg::ERR_EMPTY;
                end else begin
                    for (int i = 1; i < model_held; i++) begin
                        model_keys[i-1] = model_keys[i];
                        model_ids[i-1]  = model_ids[i];
                    end
                    model_held--;
                end
            end
            default: ;
        endcase
        if (model_held == 0) begin
            res.head_id  = '0;
            res.head_key = '0;
            res.is_empty = 1'b1;
        end else begin
            res.head_id  = model_ids[0];
            res.head_key = model_keys[0];
            res.is_empty = 1'b0;
        end
        res.count = model_held[spq_pkg::CNT_OUT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic queue_request(input logic [1:0] op, input int id, input int agility,
                                 input logic [1:0] kind, input logic alive);
        spq_pkg::t_req r;
        r.op           = op;
        r.character_id = id[spq_pkg::ID_W-1:0];
        r.agility      = agility[7:0];
        r.char_type    = kind;
        r.alive        = alive;
        request_queue.push_back(r);
    endtask

    task automatic queue_random_requests(input int n);
        int            made;
        int            burst;
        int            mode;
        int            pick;
        spq_pkg::t_req r;
        made = 0;
        while (made < n) begin
            burst = $urandom_range(40, 4);
            mode  = $urandom_range(3);
            for (int j = 0; j < burst && made < n; j++) begin
                pick = $urandom_range(99);
                if (mode == BURST_FILL)
                    r.op = pick < 85 ? spq_pkg::OP_ENQ : pick < 95 ? spq_pkg::OP_DEQ
                         : pick < 98 ? spq_pkg::OP_QUERY : OP_SPARE;
                else if (mode == BURST_DRAIN)
                    r.op = pick < 85 ? spq_pkg::OP_DEQ : pick < 95 ? spq_pkg::OP_ENQ
                         : pick < 98 ? spq_pkg::OP_QUERY : OP_SPARE;
                else
                    r.op = pick < 48 ? spq_pkg::OP_ENQ : pick < 88 ? spq_pkg::OP_DEQ
                         : pick < 96 ? spq_pkg::OP_QUERY : OP_SPARE;
                r.character_id = spq_pkg::ID_W'($urandom_range(255));
                pick = $urandom_range(9);
                r.agility = pick == 0 ? 8'd0 : pick == 1 ? 8'd255
                          : pick < 4 ? 8'($urandom_range(7)) : 8'($urandom_range(255));
                r.char_type = 2'($urandom_range(3));
                r.alive     = $urandom_range(9) != 0;
                request_queue.push_back(r);
                made++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                predicted_rsp.push_back(advance_queue_model(i_req));
            if (!i_valid || !o_stall) begin
                if (request_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_valid <= 1'b1;
                    i_req   <= request_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        spq_pkg::t_rsp want;
        i_stall <= $urandom_range(99) < recv_idle_pct;
        if (i_rst_n && o_valid && !i_stall) begin
            if (predicted_rsp.size() == 0) begin
                report_mismatch("result with none pending, head_id", int'(o_rsp.head_id), 0);
            end else begin
                want = predicted_rsp.pop_front();
                if (o_rsp.head_id !== want.head_id)
                    report_mismatch("head_id", int'(o_rsp.head_id), int'(want.head_id));
                if (o_rsp.head_key !== want.head_key)
                    report_mismatch("head_key", int'(o_rsp.head_key), int'(want.head_key));
                if (o_rsp.count !== want.count)
                    report_mismatch("count", int'(o_rsp.count), int'(want.count));
                if (o_rsp.is_empty !== want.is_empty)
                    report_mismatch("is_empty", int'(o_rsp.is_empty), int'(want.is_empty));
                if (o_rsp.error !== want.error)
                    report_mismatch("error", int'(o_rsp.error), int'(want.error));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        // empty queue, then every key form, then fill to overflow
        queue_request(spq_pkg::OP_QUERY, 0, 0, spq_pkg::TYPE_AGILE, 1'b1);
        queue_request(spq_pkg::OP_DEQ, 0, 0, spq_pkg::TYPE_AGILE, 1'b1);
        queue_request(OP_SPARE, 255, 255, TYPE_SPARE, 1'b1);
        queue_request(spq_pkg::OP_ENQ, 255, 255, spq_pkg::TYPE_AGILE, 1'b1);
        queue_request(spq_pkg::OP_ENQ, 0, 0, spq_pkg::TYPE_AGILE, 1'b1);
        queue_request(spq_pkg::OP_ENQ, 1, 255, spq_pkg::TYPE_TANK, 1'b1);
        queue_request(spq_pkg::OP_ENQ, 2, 136, spq_pkg::TYPE_AGILE, 1'b1);
        queue_request(spq_pkg::OP_ENQ, 3, 1, spq_pkg::TYPE_TANK, 1'b1);
        queue_request(spq_pkg::OP_ENQ, 4, 5, spq_pkg::TYPE_TANK, 1'b1);
        queue_request(spq_pkg::OP_ENQ, 5, 200, TYPE_OTHER, 1'b1);
        queue_request(spq_pkg::OP_ENQ, 6, 255, TYPE_SPARE, 1'b1);
        queue_request(spq_pkg::OP_ENQ, 7, 255, spq_pkg::TYPE_AGILE, 1'b0);
        queue_request(spq_pkg::OP_ENQ, 8, 1, spq_pkg::TYPE_AGILE, 1'b1);
        queue_request(spq_pkg::OP_ENQ, 9, 3, spq_pkg::TYPE_AGILE, 1'b1);
        queue_request(spq_pkg::OP_DEQ, 170, 85, spq_pkg::TYPE_TANK, 1'b0);
        queue_request(OP_SPARE, 85, 170, TYPE_OTHER, 1'b0);
        for (int i = 10; i < 16; i++)
            queue_request(spq_pkg::OP_ENQ, i, 16 * i, spq_pkg::TYPE_AGILE, 1'b1);
        queue_request(spq_pkg::OP_ENQ, 128, 254, spq_pkg::TYPE_AGILE, 1'b1);
        queue_request(spq_pkg::OP_DEQ, 0, 0, spq_pkg::TYPE_AGILE, 1'b1);
        queue_request(spq_pkg::OP_QUERY, 0, 0, spq_pkg::TYPE_AGILE, 1'b1);

        sender_idle_pct = 32;
        recv_idle_pct   = 78;
        queue_random_requests(PHASE_REQS);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (request_queue.size() != 0)
            @(posedge i_clk);

        sender_idle_pct = 78;
        recv_idle_pct   = 32;
        queue_random_requests(PHASE_REQS);
        while (request_queue.size() != 0)
            @(posedge i_clk);

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        queue_random_requests(PHASE_REQS);
        while (request_queue.size() != 0 || i_valid || predicted_rsp.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
